FILE: rtl/lrtk_pkg.sv
// Shared constants and types for the longest range top-k selector.
`timescale 1ns / 1ps

package lrtk_pkg;

	localparam int TOP_COUNT   = 5;
	localparam int MAX_RANGES  = 65536;
	localparam int INDEX_CAP   = 65536;
	localparam int RANGE_LIMIT = (MAX_RANGES > INDEX_CAP) ? INDEX_CAP : MAX_RANGES;

	localparam int ADDR_W = 64;
	localparam int IDX_W  = 16;
	localparam int CNT_W  = $clog2(RANGE_LIMIT + 1);

	typedef enum logic [1:0] {
		STATUS_OK       = 2'd0,
		STATUS_INVALID  = 2'd1,
		STATUS_OVERFLOW = 2'd2
	} status_t;

	typedef enum logic {
		ST_COLLECT,
		ST_DRAIN
	} state_t;

	typedef struct packed {
		logic              valid;
		logic [ADDR_W-1:0] start;
		logic [ADDR_W-1:0] stop;
		logic [ADDR_W-1:0] len;
		logic [IDX_W-1:0]  idx;
	} entry_t;

	typedef struct packed {
		logic ins_en;
		logic shift_en;
		logic clear;
	} cell_ctrl_t;

endpackage

FILE: rtl/lrtk_cell.sv
// One rank slot of the sorted chain: insert, shift down on insert, shift up on drain.
`timescale 1ns / 1ps

module lrtk_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  lrtk_pkg::cell_ctrl_t ctrl,
	input  lrtk_pkg::entry_t    new_ent,
	input  lrtk_pkg::entry_t    prev_ent,
	input  logic                prev_ins,
	input  lrtk_pkg::entry_t    next_ent,
	output lrtk_pkg::entry_t    ent,
	output logic                ins
);

	logic                        valid_q;
	logic [lrtk_pkg::ADDR_W-1:0] start_q;
	logic [lrtk_pkg::ADDR_W-1:0] stop_q;
	logic [lrtk_pkg::ADDR_W-1:0] len_q;
	logic [lrtk_pkg::IDX_W-1:0]  idx_q;
	lrtk_pkg::entry_t            load_ent;

	// A new range goes after every kept range of equal or greater length.
	assign ins = !valid_q || (len_q < new_ent.len);

	always_comb begin
		if (ctrl.ins_en && ins) begin
			load_ent = prev_ins ? prev_ent : new_ent;
		end else begin
			load_ent = next_ent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.clear) begin
			valid_q <= 1'b0;
		end else if ((ctrl.ins_en && ins) || ctrl.shift_en) begin
			valid_q <= load_ent.valid;
		end
	end

	always_ff @(posedge clk) begin
		if ((ctrl.ins_en && ins) || ctrl.shift_en) begin
			start_q <= load_ent.start;
			stop_q  <= load_ent.stop;
			len_q   <= load_ent.len;
			idx_q   <= load_ent.idx;
		end
	end

	assign ent = '{valid: valid_q, start: start_q, stop: stop_q, len: len_q, idx: idx_q};

endmodule

FILE: rtl/longest_range_top_k_select_top.sv
// Top level of the longest range top-k selector: counter, flags, cell chain, result drain.
`timescale 1ns / 1ps

// Ranges enter one per cycle and are sorted on arrival into a chain of five rank
// cells: each cell compares its kept length against the new length and either
// holds, takes the new range, or takes its upper neighbor's range, all in the
// accept cycle. A range that is not the last of its list produces no result and
// the next range is accepted in the following cycle. On the last range the
// input stalls while results drain from the head cell, one per cycle when the
// output is not stalled: up to five ranked results, or a single error result if
// any range had its end before its start or the list held more than 65536
// ranges. The input is taken again in the cycle after the final result leaves.
module longest_range_top_k_select_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [lrtk_pkg::ADDR_W-1:0] range_start,
	input  logic [lrtk_pkg::ADDR_W-1:0] range_end,
	input  logic                        last_range,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [lrtk_pkg::ADDR_W-1:0] ranked_start,
	output logic [lrtk_pkg::ADDR_W-1:0] ranked_end,
	output logic [lrtk_pkg::IDX_W-1:0]  arrival_index,
	output logic [1:0]                  status,
	output logic                        last_result
);

	lrtk_pkg::state_t            state_q;
	lrtk_pkg::state_t            state_nxt;
	logic [lrtk_pkg::CNT_W-1:0]  range_cnt_q;
	logic                        invalid_q;
	logic                        overflow_q;
	lrtk_pkg::status_t           err_status_q;

	logic                        in_acc;
	logic                        out_acc;
	logic                        at_limit;
	logic                        bad_range;
	logic                        err_now;
	logic                        drain_err;
	lrtk_pkg::entry_t            new_ent;
	lrtk_pkg::cell_ctrl_t        ctrl;

	lrtk_pkg::entry_t            ent     [lrtk_pkg::TOP_COUNT];
	lrtk_pkg::entry_t            prev_ent[lrtk_pkg::TOP_COUNT];
	lrtk_pkg::entry_t            next_ent[lrtk_pkg::TOP_COUNT];
	logic [lrtk_pkg::TOP_COUNT-1:0] ins;
	logic [lrtk_pkg::TOP_COUNT-1:0] prev_ins;
	logic [lrtk_pkg::TOP_COUNT-1:0] valid_vec;

	assign in_stall = (state_q == lrtk_pkg::ST_DRAIN);
	assign in_acc   = in_valid && !in_stall;
	assign out_acc  = out_valid && !out_stall;

	assign at_limit  = (range_cnt_q >= lrtk_pkg::CNT_W'(lrtk_pkg::RANGE_LIMIT));
	assign bad_range = (range_end < range_start);
	assign err_now   = invalid_q || overflow_q || at_limit || bad_range;
	assign drain_err = (err_status_q != lrtk_pkg::STATUS_OK);

	assign new_ent = '{
		valid: 1'b1,
		start: range_start,
		stop:  range_end,
		len:   range_end - range_start,
		idx:   range_cnt_q[lrtk_pkg::IDX_W-1:0]
	};

	assign ctrl.ins_en   = in_acc && !at_limit && !bad_range;
	assign ctrl.shift_en = out_acc && !drain_err;
	assign ctrl.clear    = out_acc && drain_err;

	for (genvar i = 0; i < lrtk_pkg::TOP_COUNT; i++) begin : g_chain
		if (i == 0) begin : g_head
			assign prev_ent[i] = '0;
			assign prev_ins[i] = 1'b0;
		end else begin : g_body
			assign prev_ent[i] = ent[i-1];
			assign prev_ins[i] = ins[i-1];
		end
		if (i == lrtk_pkg::TOP_COUNT - 1) begin : g_tail
			assign next_ent[i] = '0;
		end else begin : g_mid
			assign next_ent[i] = ent[i+1];
		end
		assign valid_vec[i] = ent[i].valid;

		lrtk_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.new_ent  (new_ent),
			.prev_ent (prev_ent[i]),
			.prev_ins (prev_ins[i]),
			.next_ent (next_ent[i]),
			.ent      (ent[i]),
			.ins      (ins[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= lrtk_pkg::ST_COLLECT;
			range_cnt_q  <= '0;
			invalid_q    <= 1'b0;
			overflow_q   <= 1'b0;
			err_status_q <= lrtk_pkg::STATUS_OK;
		end else begin
			state_q <= state_nxt;
			if (in_acc) begin
				if (last_range) begin
					// list done: latch the verdict, restart the count
					range_cnt_q <= '0;
					invalid_q   <= 1'b0;
					overflow_q  <= 1'b0;
					if (!err_now) begin
						err_status_q <= lrtk_pkg::STATUS_OK;
					end else if (invalid_q || (!at_limit && bad_range)) begin
						err_status_q <= lrtk_pkg::STATUS_INVALID;
					end else begin
						err_status_q <= lrtk_pkg::STATUS_OVERFLOW;
					end
				end else if (at_limit) begin
					overflow_q <= 1'b1;
				end else begin
					range_cnt_q <= range_cnt_q + 1'b1;
					if (bad_range) begin
						invalid_q <= 1'b1;
					end
				end
			end
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			lrtk_pkg::ST_COLLECT: begin
				if (in_acc && last_range) begin
					state_nxt = lrtk_pkg::ST_DRAIN;
				end
			end
			lrtk_pkg::ST_DRAIN: begin
				if (!drain_err && !ent[0].valid) begin
					state_nxt = lrtk_pkg::ST_COLLECT;
				end else if (out_acc && (drain_err || !next_ent[0].valid)) begin
					state_nxt = lrtk_pkg::ST_COLLECT;
				end
			end
			default: begin
				state_nxt = lrtk_pkg::ST_COLLECT;
			end
		endcase
	end

	assign out_valid     = (state_q == lrtk_pkg::ST_DRAIN) && (drain_err || ent[0].valid);
	assign ranked_start  = drain_err ? '0 : ent[0].start;
	assign ranked_end    = drain_err ? '0 : ent[0].stop;
	assign arrival_index = drain_err ? '0 : ent[0].idx;
	assign status        = err_status_q;
	assign last_result   = drain_err || !next_ent[0].valid;

	logic [lrtk_pkg::TOP_COUNT-1:0] order_ok;

	always_comb begin
		order_ok = '1;
		for (int i = 0; i < lrtk_pkg::TOP_COUNT - 1; i++) begin
			order_ok[i] = !ent[i+1].valid || (ent[i].len >= ent[i+1].len);
		end
	end

`ifndef ASSERT_OFF
	a_valid_packed: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot({1'b0, valid_vec} + 1'b1))
		else $error("kept ranges are not packed from the head cell");

	a_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		&order_ok)
		else $error("kept ranges are not in descending length order");

	a_last_starts_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && last_range) |=> out_valid)
		else $error("no result after the last range of a list");

	a_final_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && last_result) |=> (!out_valid && !in_stall))
		else $error("results continue after the final result");
`endif

endmodule
